// ----- rtl/wavpd_pkg.sv -----
package wavpd_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_stream;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         result_kind;
        logic signed [15:0] mono_sample;
        logic [31:0]        sample_rate;
        logic [3:0]         channel_count;
        logic [2:0]         error_code;
    } t_out_item;

    localparam logic [1:0] KIND_FORMAT = 2'd0;
    localparam logic [1:0] KIND_SAMPLE = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    localparam logic [2:0] ERR_NONE        = 3'd0;
    localparam logic [2:0] ERR_NOT_RIFF    = 3'd1;
    localparam logic [2:0] ERR_NOT_WAVE    = 3'd2;
    localparam logic [2:0] ERR_BAD_FORMAT  = 3'd3;
    localparam logic [2:0] ERR_MISSING     = 3'd4;
    localparam logic [2:0] ERR_DATA_FIRST  = 3'd5;

endpackage

// ----- rtl/wav_pcm16_parser_downmix_core.sv -----
// WAV parser with mono downmix. Takes one byte of a RIFF/WAVE stream per input transaction,
// checks the RIFF and WAVE tags, walks the chunk list, reports an accepted 16-bit PCM fmt
// chunk (1 to MAX_CHANNELS channels) and then turns each frame of the data chunk into one
// Q1.15 mono sample, the channel sum divided by the channel count, truncated toward zero.
// Errors halt the parser until reset; after the data chunk all input is taken and ignored.
// A byte is taken whenever the parser is idle and no result waits in the buffer; the byte that
// completes a frame also runs the shared restoring divider, one quotient bit per cycle, and
// the next byte is taken only after the divider has finished with that frame.
// Results go through a one-entry buffer ahead of the output register, so the input side
// keeps going while one result waits to be taken.
module wav_pcm16_parser_downmix_core #(
    parameter int MAX_CHANNELS = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  wavpd_pkg::t_in_item  i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output wavpd_pkg::t_out_item o_out_item
);
    import wavpd_pkg::*;

    localparam int SUM_W = 16 + $clog2(MAX_CHANNELS);
    localparam int CH_W  = $clog2(MAX_CHANNELS + 1);
    localparam int IT_W  = $clog2(SUM_W + 1);

    localparam logic [31:0] TAG_RIFF = 32'h52494646;
    localparam logic [31:0] TAG_WAVE = 32'h57415645;
    localparam logic [31:0] TAG_FMT  = 32'h666D7420;
    localparam logic [31:0] TAG_DATA = 32'h64617461;

    typedef enum logic [9:0] {
        PH_RIFF  = 10'b0000000001,
        PH_RSIZE = 10'b0000000010,
        PH_WAVE  = 10'b0000000100,
        PH_ID    = 10'b0000001000,
        PH_LEN   = 10'b0000010000,
        PH_FMT   = 10'b0000100000,
        PH_DATA  = 10'b0001000000,
        PH_SKIP  = 10'b0010000000,
        PH_PAD   = 10'b0100000000,
        PH_STOP  = 10'b1000000000
    } t_phase;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_FIN  = 3'b100
    } t_state;

    t_phase                  r_phase, n_phase;
    t_state                  r_st, n_st;
    logic [31:0]             r_cnt, n_cnt;
    logic [31:0]             r_tag, n_tag;
    logic [31:0]             r_len, n_len;
    logic [15:0]             r_fmt, n_fmt;
    logic [15:0]             r_chan, n_chan;
    logic [31:0]             r_rate, n_rate;
    logic [15:0]             r_bits, n_bits;
    logic                    r_fmt_seen, n_fmt_seen;
    logic                    r_data_seen, n_data_seen;
    logic [7:0]              r_low, n_low;
    logic signed [SUM_W-1:0] r_sum, n_sum;
    logic [CH_W-1:0]         r_pos, n_pos;
    logic [SUM_W-1:0]        r_dq, n_dq;
    logic [CH_W-1:0]         r_rem, n_rem;
    logic                    r_neg, n_neg;
    logic [IT_W-1:0]         r_it, n_it;
    logic                    r_pend_valid, n_pend_valid;
    t_out_item               r_pend, n_pend;
    logic                    r_out_valid, n_out_valid;
    t_out_item               r_out, n_out;

    logic                    accept;
    logic                    res_v;
    t_out_item               res;
    logic [7:0]              b;
    logic [31:0]             cnt1;
    logic [31:0]             len_f;
    logic [15:0]             bits_f;
    logic signed [15:0]      smp;
    logic signed [SUM_W-1:0] sum_f;
    logic [CH_W-1:0]         pos1;
    logic [CH_W:0]           trial;
    logic [CH_W:0]           dvs;
    logic                    qbit;

    assign o_in_ready  = (r_st == ST_IDLE) && !r_pend_valid;
    assign accept      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    always_comb begin
        n_phase     = r_phase;
        n_st        = r_st;
        n_cnt       = r_cnt;
        n_tag       = r_tag;
        n_len       = r_len;
        n_fmt       = r_fmt;
        n_chan      = r_chan;
        n_rate      = r_rate;
        n_bits      = r_bits;
        n_fmt_seen  = r_fmt_seen;
        n_data_seen = r_data_seen;
        n_low       = r_low;
        n_sum       = r_sum;
        n_pos       = r_pos;
        n_dq        = r_dq;
        n_rem       = r_rem;
        n_neg       = r_neg;
        n_it        = r_it;
        res_v       = 1'b0;
        res         = '0;

        b      = i_in_item.data_byte;
        cnt1   = r_cnt + 32'd1;
        len_f  = {b, r_len[23:0]};
        bits_f = {b, r_bits[7:0]};
        smp    = {b, r_low};
        sum_f  = r_sum + SUM_W'(smp);
        pos1   = r_pos + 1'b1;
        dvs    = {1'b0, r_chan[CH_W-1:0]};
        trial  = {r_rem, r_dq[SUM_W-1]};
        qbit   = (trial >= dvs);

        if (accept && r_phase != PH_STOP) begin
            if (i_in_item.end_of_stream) begin
                n_phase = PH_STOP;
                if (!r_data_seen) begin
                    res_v            = 1'b1;
                    res.result_kind  = KIND_ERROR;
                    res.error_code   = ERR_MISSING;
                end
            end else begin
                unique case (r_phase)
                    PH_RIFF, PH_WAVE, PH_ID: begin
                        n_tag = {r_tag[23:0], b};
                        n_cnt = cnt1;
                        if (r_cnt[1:0] == 2'd3) begin
                            n_cnt = '0;
                            if (r_phase == PH_RIFF) begin
                                if (n_tag != TAG_RIFF) begin
                                    n_phase         = PH_STOP;
                                    res_v           = 1'b1;
                                    res.result_kind = KIND_ERROR;
                                    res.error_code  = ERR_NOT_RIFF;
                                end else begin
                                    n_phase = PH_RSIZE;
                                end
                            end else if (r_phase == PH_WAVE) begin
                                if (n_tag != TAG_WAVE) begin
                                    n_phase         = PH_STOP;
                                    res_v           = 1'b1;
                                    res.result_kind = KIND_ERROR;
                                    res.error_code  = ERR_NOT_WAVE;
                                end else begin
                                    n_phase = PH_ID;
                                end
                            end else begin
                                n_len   = '0;
                                n_phase = PH_LEN;
                            end
                        end
                    end
                    PH_RSIZE: begin
                        n_cnt = cnt1;
                        if (r_cnt[1:0] == 2'd3) begin
                            n_cnt   = '0;
                            n_phase = PH_WAVE;
                        end
                    end
                    PH_LEN: begin
                        n_cnt = cnt1;
                        case (r_cnt[1:0])
                            2'd0:    n_len[7:0]   = b;
                            2'd1:    n_len[15:8]  = b;
                            2'd2:    n_len[23:16] = b;
                            default: n_len[31:24] = b;
                        endcase
                        if (r_cnt[1:0] == 2'd3) begin
                            n_cnt = '0;
                            if (r_tag == TAG_FMT) begin
                                if (len_f < 32'd16) begin
                                    n_phase         = PH_STOP;
                                    res_v           = 1'b1;
                                    res.result_kind = KIND_ERROR;
                                    res.error_code  = ERR_BAD_FORMAT;
                                end else begin
                                    n_phase = PH_FMT;
                                end
                            end else if (r_tag == TAG_DATA) begin
                                if (!r_fmt_seen) begin
                                    n_phase         = PH_STOP;
                                    res_v           = 1'b1;
                                    res.result_kind = KIND_ERROR;
                                    res.error_code  = ERR_DATA_FIRST;
                                end else begin
                                    n_data_seen = 1'b1;
                                    n_sum       = '0;
                                    n_pos       = '0;
                                    n_phase     = (len_f == 32'd0) ? PH_STOP : PH_DATA;
                                end
                            end else begin
                                n_phase = (len_f == 32'd0) ? PH_ID : PH_SKIP;
                            end
                        end
                    end
                    PH_FMT: begin
                        n_cnt = cnt1;
                        case (r_cnt[3:0])
                            4'd0:    n_fmt  = {8'h00, b};
                            4'd1:    n_fmt[15:8] = b;
                            4'd2:    n_chan = {8'h00, b};
                            4'd3:    n_chan[15:8] = b;
                            4'd4:    n_rate = {24'h000000, b};
                            4'd5:    n_rate[15:8]  = b;
                            4'd6:    n_rate[23:16] = b;
                            4'd7:    n_rate[31:24] = b;
                            4'd14:   n_bits = {8'h00, b};
                            4'd15:   n_bits = bits_f;
                            default: n_cnt = cnt1;
                        endcase
                        if (r_cnt[3:0] == 4'd15) begin
                            if (r_fmt != 16'd1 || bits_f != 16'd16 || r_chan == 16'd0 ||
                                r_chan > 16'(MAX_CHANNELS)) begin
                                n_phase         = PH_STOP;
                                res_v           = 1'b1;
                                res.result_kind = KIND_ERROR;
                                res.error_code  = ERR_BAD_FORMAT;
                            end else begin
                                n_fmt_seen        = 1'b1;
                                res_v             = 1'b1;
                                res.result_kind   = KIND_FORMAT;
                                res.sample_rate   = r_rate;
                                res.channel_count = r_chan[3:0];
                                if (r_len > 32'd16) begin
                                    n_phase = PH_SKIP;
                                end else begin
                                    n_cnt   = '0;
                                    n_phase = r_len[0] ? PH_PAD : PH_ID;
                                end
                            end
                        end
                    end
                    PH_SKIP: begin
                        n_cnt = cnt1;
                        if (cnt1 >= r_len) begin
                            n_cnt   = '0;
                            n_phase = r_len[0] ? PH_PAD : PH_ID;
                        end
                    end
                    PH_PAD: begin
                        n_cnt   = '0;
                        n_phase = PH_ID;
                    end
                    PH_DATA: begin
                        n_cnt = cnt1;
                        if (!r_cnt[0]) begin
                            n_low = b;
                        end else if (16'(pos1) >= r_chan) begin
                            // frame complete: hand the sum magnitude to the divider
                            n_neg = sum_f[SUM_W-1];
                            n_dq  = sum_f[SUM_W-1] ? SUM_W'(-sum_f) : SUM_W'(sum_f);
                            n_rem = '0;
                            n_it  = IT_W'(SUM_W);
                            n_st  = ST_DIV;
                            n_sum = '0;
                            n_pos = '0;
                        end else begin
                            n_sum = sum_f;
                            n_pos = pos1;
                        end
                        if (cnt1 >= r_len) begin
                            n_phase = PH_STOP;
                        end
                    end
                    default: n_phase = PH_STOP;
                endcase
            end
        end

        unique case (r_st)
            ST_IDLE: n_st = n_st;
            ST_DIV: begin
                // restoring step, quotient bits shift in where dividend bits leave
                n_rem = qbit ? CH_W'(trial - dvs) : trial[CH_W-1:0];
                n_dq  = {r_dq[SUM_W-2:0], qbit};
                n_it  = r_it - 1'b1;
                if (r_it == IT_W'(1)) begin
                    n_st = ST_FIN;
                end
            end
            ST_FIN: begin
                res_v           = 1'b1;
                res.result_kind = KIND_SAMPLE;
                res.mono_sample = r_neg ? 16'(-r_dq) : 16'(r_dq);
                n_st            = ST_IDLE;
            end
            default: n_st = ST_IDLE;
        endcase
    end

    // result buffer ahead of the output register
    always_comb begin
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out        = r_out;
        n_pend_valid = r_pend_valid;
        n_pend       = r_pend;
        if (r_pend_valid && !n_out_valid) begin
            n_out        = r_pend;
            n_out_valid  = 1'b1;
            n_pend_valid = 1'b0;
        end
        if (res_v) begin
            if (!n_out_valid) begin
                n_out       = res;
                n_out_valid = 1'b1;
            end else begin
                n_pend       = res;
                n_pend_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_RIFF;
            r_st         <= ST_IDLE;
            r_cnt        <= '0;
            r_tag        <= '0;
            r_len        <= '0;
            r_fmt        <= '0;
            r_chan       <= '0;
            r_rate       <= '0;
            r_bits       <= '0;
            r_fmt_seen   <= 1'b0;
            r_data_seen  <= 1'b0;
            r_low        <= '0;
            r_sum        <= '0;
            r_pos        <= '0;
            r_it         <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_phase      <= n_phase;
            r_st         <= n_st;
            r_cnt        <= n_cnt;
            r_tag        <= n_tag;
            r_len        <= n_len;
            r_fmt        <= n_fmt;
            r_chan       <= n_chan;
            r_rate       <= n_rate;
            r_bits       <= n_bits;
            r_fmt_seen   <= n_fmt_seen;
            r_data_seen  <= n_data_seen;
            r_low        <= n_low;
            r_sum        <= n_sum;
            r_pos        <= n_pos;
            r_it         <= n_it;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dq   <= n_dq;
        r_rem  <= n_rem;
        r_neg  <= n_neg;
        r_pend <= n_pend;
        r_out  <= n_out;
    end

endmodule

// ----- rtl/wavpd_checker.sv -----
module wavpd_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_ready,
    input wavpd_pkg::t_in_item  i_in_item,
    input logic                 o_out_valid,
    input logic                 i_out_ready,
    input wavpd_pkg::t_out_item o_out_item
);
    import wavpd_pkg::*;

    // a waiting result stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("output transaction dropped or changed while stalled");

    // format report carries no sample and no error
    a_fmt_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.result_kind == KIND_FORMAT |->
        o_out_item.error_code == ERR_NONE && o_out_item.mono_sample == 16'sd0)
        else $error("format transaction with stray fields");

    // error report always names a cause
    a_err_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.result_kind == KIND_ERROR |->
        o_out_item.error_code != ERR_NONE && o_out_item.sample_rate == 32'd0)
        else $error("error transaction without a cause");

    // an error halts the parser, nothing follows it
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && o_out_item.result_kind == KIND_ERROR |=> !o_out_valid)
        else $error("transaction after an error");

endmodule

bind wav_pcm16_parser_downmix_core wavpd_checker u_wavpd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_item   (i_in_item),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);

// ----- verif/wav_pcm16_parser_downmix_core_tb.sv -----
module wav_pcm16_parser_downmix_core_tb;

    import wavpd_pkg::*;

    localparam int MAX_CH         = 8;
    localparam int HOLD_CYCLES    = 300;
    localparam int TAIL_CYCLES    = 48;
    localparam int WATCHDOG_LIMIT = 2000;

    localparam logic [31:0] TAG_RIFF = "RIFF";
    localparam logic [31:0] TAG_WAVE = "WAVE";
    localparam logic [31:0] TAG_FMT  = "fmt ";
    localparam logic [31:0] TAG_DATA = "data";

    typedef enum logic [3:0] {
        ST_RIFF_TAG, ST_RIFF_SIZE, ST_WAVE_TAG, ST_CHUNK_ID, ST_CHUNK_LEN, ST_FMT_BODY,
        ST_DATA_BODY, ST_SKIP_BODY, ST_PAD_BYTE, ST_FINISHED, ST_HALTED
    } t_parse_state;

    typedef struct packed {
        logic [7:0] b;
        logic       eos;
        logic       typed;
        t_out_item  want;
    } t_feed_row;

    localparam t_out_item NO_RESULT     = '0;
    localparam t_out_item FMT_AT_LIMITS = '{KIND_FORMAT, 16'sd0, 32'hFFFF_FFFF, 4'd8, ERR_NONE};

    // header plus a fmt chunk with 8 channels and the largest rate
    localparam t_feed_row OPENING [36] = '{
        '{"R", 1'b0, 1'b0, NO_RESULT},   '{"I", 1'b0, 1'b0, NO_RESULT},
        '{"F", 1'b0, 1'b0, NO_RESULT},   '{"F", 1'b0, 1'b0, NO_RESULT},
        '{8'hFF, 1'b0, 1'b0, NO_RESULT}, '{8'h00, 1'b0, 1'b0, NO_RESULT},
        '{8'h80, 1'b0, 1'b0, NO_RESULT}, '{8'h7F, 1'b0, 1'b0, NO_RESULT},
        '{"W", 1'b0, 1'b0, NO_RESULT},   '{"A", 1'b0, 1'b0, NO_RESULT},
        '{"V", 1'b0, 1'b0, NO_RESULT},   '{"E", 1'b0, 1'b0, NO_RESULT},
        '{"f", 1'b0, 1'b0, NO_RESULT},   '{"m", 1'b0, 1'b0, NO_RESULT},
        '{"t", 1'b0, 1'b0, NO_RESULT},   '{" ", 1'b0, 1'b0, NO_RESULT},
        '{8'h10, 1'b0, 1'b0, NO_RESULT}, '{8'h00, 1'b0, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, 1'b0, NO_RESULT}, '{8'h00, 1'b0, 1'b0, NO_RESULT},
        '{8'h01, 1'b0, 1'b0, NO_RESULT}, '{8'h00, 1'b0, 1'b0, NO_RESULT},
        '{8'h08, 1'b0, 1'b0, NO_RESULT}, '{8'h00, 1'b0, 1'b0, NO_RESULT},
        '{8'hFF, 1'b0, 1'b0, NO_RESULT}, '{8'hFF, 1'b0, 1'b0, NO_RESULT},
        '{8'hFF, 1'b0, 1'b0, NO_RESULT}, '{8'hFF, 1'b0, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, 1'b0, NO_RESULT}, '{8'hFF, 1'b0, 1'b0, NO_RESULT},
        '{8'h55, 1'b0, 1'b0, NO_RESULT}, '{8'hAA, 1'b0, 1'b0, NO_RESULT},
        '{8'h10, 1'b0, 1'b0, NO_RESULT}, '{8'h00, 1'b0, 1'b0, NO_RESULT},
        '{8'h10, 1'b0, 1'b0, NO_RESULT}, '{8'h00, 1'b0, 1'b1, FMT_AT_LIMITS}
    };

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    t_in_item  in_item   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_item out_item;

    t_feed_row feed [$];
    t_out_item pending_results [$];
    int        offer_row      = 0;
    int        bytes_taken    = 0;
    int        results_seen   = 0;
    int        quiet_cycles   = 0;
    int        mismatch_count = 0;
    int        hold_mark      = 0;
    int        quiet_from     = 0;

    // parser state mirrored by the predictor
    t_parse_state p_state    = ST_RIFF_TAG;
    logic [31:0]  p_count    = '0;
    logic [31:0]  p_tag      = '0;
    logic [31:0]  p_len      = '0;
    logic [15:0]  p_fmt_code = '0;
    logic [15:0]  p_chans    = '0;
    logic [31:0]  p_rate     = '0;
    logic [15:0]  p_bits     = '0;
    logic         p_fmt_ok   = 1'b0;
    logic         p_in_data  = 1'b0;
    logic [7:0]   p_low      = '0;
    int           p_sum      = 0;
    int           p_pos      = 0;

    wav_pcm16_parser_downmix_core #(.MAX_CHANNELS(MAX_CH)) i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_item  (in_item),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_item (out_item)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic bit stop_parse(input logic [2:0] code, output t_out_item res);
        p_state = ST_HALTED;
        res = '0;
        res.result_kind = KIND_ERROR;
        res.error_code = code;
        return 1'b1;
    endfunction

    function automatic void close_chunk();
        p_state = p_len[0] ? ST_PAD_BYTE : ST_CHUNK_ID;
        p_count = '0;
    endfunction

    function automatic bit parse_wav_byte(input t_in_item it, output t_out_item res);
        logic [31:0] at;
        logic [15:0] raw;
        int          mono;
        bit          produced;
        res = '0;
        produced = 1'b0;
        if (p_state == ST_FINISHED || p_state == ST_HALTED)
            return 1'b0;
        if (it.end_of_stream) begin
            if (p_in_data) begin
                p_state = ST_FINISHED;
                return 1'b0;
            end
            return stop_parse(ERR_MISSING, res);
        end
        at = p_count;
        p_count = at + 1;
        case (p_state)
            ST_RIFF_TAG, ST_WAVE_TAG, ST_CHUNK_ID: begin
                p_tag = {p_tag[23:0], it.data_byte};
                if (p_count < 4)
                    return 1'b0;
                p_count = '0;
                if (p_state == ST_RIFF_TAG) begin
                    if (p_tag != TAG_RIFF)
                        return stop_parse(ERR_NOT_RIFF, res);
                    p_state = ST_RIFF_SIZE;
                end else if (p_state == ST_WAVE_TAG) begin
                    if (p_tag != TAG_WAVE)
                        return stop_parse(ERR_NOT_WAVE, res);
                    p_state = ST_CHUNK_ID;
                end else begin
                    p_len = '0;
                    p_state = ST_CHUNK_LEN;
                end
            end
            ST_RIFF_SIZE: begin
                if (p_count >= 4) begin
                    p_count = '0;
                    p_state = ST_WAVE_TAG;
                end
            end
            ST_CHUNK_LEN: begin
                p_len = p_len | ({24'd0, it.data_byte} << (8 * at[1:0]));
                if (p_count < 4)
                    return 1'b0;
                p_count = '0;
                if (p_tag == TAG_FMT) begin
                    if (p_len < 16)
                        return stop_parse(ERR_BAD_FORMAT, res);
                    p_state = ST_FMT_BODY;
                end else if (p_tag == TAG_DATA) begin
                    if (!p_fmt_ok)
                        return stop_parse(ERR_DATA_FIRST, res);
                    p_in_data = 1'b1;
                    p_sum = 0;
                    p_pos = 0;
                    p_state = (p_len == 0) ? ST_FINISHED : ST_DATA_BODY;
                end else begin
                    p_state = (p_len == 0) ? ST_CHUNK_ID : ST_SKIP_BODY;
                end
            end
            ST_FMT_BODY: begin
                case (at)
                    0:  p_fmt_code = {8'd0, it.data_byte};
                    1:  p_fmt_code[15:8] = it.data_byte;
                    2:  p_chans = {8'd0, it.data_byte};
                    3:  p_chans[15:8] = it.data_byte;
                    4:  p_rate = {24'd0, it.data_byte};
                    5:  p_rate[15:8] = it.data_byte;
                    6:  p_rate[23:16] = it.data_byte;
                    7:  p_rate[31:24] = it.data_byte;
                    14: p_bits = {8'd0, it.data_byte};
                    15: p_bits[15:8] = it.data_byte;
                    default: ;
                endcase
                if (p_count < 16)
                    return 1'b0;
                if (p_fmt_code != 1 || p_bits != 16 || p_chans == 0 || p_chans > MAX_CH)
                    return stop_parse(ERR_BAD_FORMAT, res);
                p_fmt_ok = 1'b1;
                if (p_len > 16)
                    p_state = ST_SKIP_BODY;
                else
                    close_chunk();
                res.result_kind = KIND_FORMAT;
                res.sample_rate = p_rate;
                res.channel_count = p_chans[3:0];
                produced = 1'b1;
            end
            ST_SKIP_BODY: begin
                if (p_count >= p_len)
                    close_chunk();
            end
            ST_PAD_BYTE: begin
                p_state = ST_CHUNK_ID;
                p_count = '0;
            end
            ST_DATA_BODY: begin
                if (!at[0]) begin
                    p_low = it.data_byte;
                end else begin
                    raw = {it.data_byte, p_low};
                    p_sum = p_sum + int'($signed(raw));
                    p_pos = p_pos + 1;
                    if (p_pos >= int'(p_chans)) begin
                        // int division truncates toward zero
                        mono = p_sum / int'(p_chans);
                        p_sum = 0;
                        p_pos = 0;
                        res.result_kind = KIND_SAMPLE;
                        res.mono_sample = mono[15:0];
                        produced = 1'b1;
                    end
                end
                if (p_count >= p_len)
                    p_state = ST_FINISHED;
            end
            default: p_state = ST_HALTED;
        endcase
        return produced;
    endfunction

    function automatic void queue_byte(input logic [7:0] b, input logic eos);
        feed.insert(feed.size(), t_feed_row'{b, eos, 1'b0, NO_RESULT});
    endfunction

    function automatic void queue_le32(input logic [31:0] w);
        for (int i = 0; i < 4; i++)
            queue_byte(w[8*i +: 8], 1'b0);
    endfunction

    function automatic void queue_tag(input logic [31:0] id);
        for (int i = 3; i >= 0; i--)
            queue_byte(id[8*i +: 8], 1'b0);
    endfunction

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        if (mismatch_count < 40)
            $display("mismatch in %s at result %0d: got %0h, expected %0h",
                     what, results_seen, got, want);
        mismatch_count++;
    endtask

    // prediction on input transactions, checking on output transactions
    always @(posedge clk) begin
        t_out_item calc;
        t_out_item want;
        bit        made;
        bit        took;
        took = 1'b0;
        if (rst_n) begin
            if (in_valid && in_ready === 1'b1) begin
                took = 1'b1;
                made = parse_wav_byte(in_item, calc);
                if (feed[offer_row].typed)
                    pending_results.insert(pending_results.size(), feed[offer_row].want);
                else if (made)
                    pending_results.insert(pending_results.size(), calc);
                bytes_taken <= bytes_taken + 1;
            end
            if (out_valid === 1'b1 && out_ready) begin
                took = 1'b1;
                if (pending_results.size() == 0) begin
                    flag_mismatch("unexpected result, kind", 32'(out_item.result_kind), '0);
                end else begin
                    want = pending_results.pop_front();
                    if (out_item.result_kind !== want.result_kind)
                        flag_mismatch("result_kind", 32'(out_item.result_kind),
                                      32'(want.result_kind));
                    if (out_item.mono_sample !== want.mono_sample)
                        flag_mismatch("mono_sample", 32'(out_item.mono_sample),
                                      32'(want.mono_sample));
                    if (out_item.sample_rate !== want.sample_rate)
                        flag_mismatch("sample_rate", out_item.sample_rate, want.sample_rate);
                    if (out_item.channel_count !== want.channel_count)
                        flag_mismatch("channel_count", 32'(out_item.channel_count),
                                      32'(want.channel_count));
                    if (out_item.error_code !== want.error_code)
                        flag_mismatch("error_code", 32'(out_item.error_code),
                                      32'(want.error_code));
                end
                results_seen <= results_seen + 1;
            end
            quiet_cycles <= took ? 0 : quiet_cycles + 1;
        end
    end

    // receiver: short random stalls, one long hold once the data chunk is flowing
    initial begin
        bit held;
        held = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            if (!held && bytes_taken >= hold_mark) begin
                held = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end else if (bytes_taken < quiet_from && ((bytes_taken >> 7) % 3) != 1 &&
                         $urandom_range(0, 3) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
        end
    end

    initial begin
        wait (rst_n === 1'b1);
        while (quiet_cycles < WATCHDOG_LIMIT)
            @(posedge clk);
        $display("Verification failed");
        $finish;
    end

    initial begin
        int          n_chunks;
        int          chans;
        int          data_chans;
        int          flen;
        int          ulen;
        int          body_len;
        int          nb;
        int          mode;
        logic [31:0] id;
        logic [31:0] rate;
        logic [15:0] smp;
        bit          cut_short;

        foreach (OPENING[r])
            feed.insert(feed.size(), OPENING[r]);
        data_chans = 8;

        // chunks ahead of data: unknown ones (odd, empty, longer) and repeated fmt
        n_chunks = $urandom_range(3, 7);
        for (int k = 0; k < n_chunks; k++) begin
            if ($urandom_range(0, 2) == 0) begin
                chans = $urandom_range(1, MAX_CH);
                case ($urandom_range(0, 3))
                    0: rate = '0;
                    1: rate = '1;
                    2: rate = 32'd44100;
                    default: rate = $urandom;
                endcase
                flen = $urandom_range(16, 19);
                queue_tag(TAG_FMT);
                queue_le32(flen);
                queue_le32({16'(chans), 16'h0001});
                queue_le32(rate);
                queue_le32($urandom);
                queue_le32({16'd16, 16'($urandom)});
                for (int i = 16; i < flen; i++)
                    queue_byte(8'($urandom), 1'b0);
                if (flen % 2)
                    queue_byte(8'($urandom), 1'b0);
                data_chans = chans;
            end else begin
                do
                    id = $urandom;
                while (id == TAG_FMT || id == TAG_DATA);
                ulen = ($urandom_range(0, 5) == 0) ? $urandom_range(13, 60)
                                                   : $urandom_range(0, 12);
                queue_tag(id);
                queue_le32(ulen);
                for (int i = 0; i < ulen; i++)
                    queue_byte(8'($urandom), 1'b0);
                if (ulen % 2)
                    queue_byte(8'($urandom), 1'b0);
            end
        end

        // data chunk, either declared longer and cut by end of stream, or complete
        body_len = $urandom_range(1000, 1300);
        cut_short = ($urandom_range(0, 1) == 1);
        queue_tag(TAG_DATA);
        if (!cut_short)
            queue_le32(body_len);
        else if ($urandom_range(0, 1))
            queue_le32(32'hFFFF_FFFE);
        else
            queue_le32(body_len + $urandom_range(1, 40));
        hold_mark = feed.size() + 40;
        nb = 0;
        while (nb < body_len) begin
            mode = $urandom_range(0, 7);
            for (int c = 0; c < data_chans && nb < body_len; c++) begin
                case (mode)
                    0: smp = 16'h7FFF;
                    1: smp = 16'h8000;
                    2: begin
                        case ($urandom_range(0, 4))
                            0: smp = 16'h7FFF;
                            1: smp = 16'h8000;
                            2: smp = 16'hFFFF;
                            3: smp = 16'h0001;
                            default: smp = 16'h0000;
                        endcase
                    end
                    default: smp = 16'($urandom);
                endcase
                queue_byte(smp[7:0], 1'b0);
                nb++;
                if (nb < body_len) begin
                    queue_byte(smp[15:8], 1'b0);
                    nb++;
                end
            end
        end
        if (cut_short)
            queue_byte(8'($urandom), 1'b1);
        // trailing bytes and end of stream after the parser is done
        repeat ($urandom_range(1, 4))
            queue_byte(8'($urandom), 1'b0);
        queue_byte(8'($urandom), 1'b1);
        quiet_from = feed.size() * 85 / 100;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        for (int idx = 0; idx < feed.size(); idx++) begin
            if (idx < quiet_from && ((idx >> 7) % 3) != 2 && $urandom_range(0, 4) == 0) begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
            in_valid  <= 1'b1;
            in_item   <= '{feed[idx].b, feed[idx].eos};
            offer_row <= idx;
            @(posedge clk);
            while (in_ready !== 1'b1)
                @(posedge clk);
        end
        in_valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/wavpd_pkg.sv
rtl/wav_pcm16_parser_downmix_core.sv
rtl/wavpd_checker.sv
verif/wav_pcm16_parser_downmix_core_tb.sv
